FILE: rtl/core/scd_pkg.sv
// shared types and constants for the serial clock divisor search block
`default_nettype none

package scd_pkg;

   localparam int unsigned WORD_W     = 32;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned Q_W        = 9;
   localparam int unsigned DIV_W      = 16;
   localparam int unsigned STATUS_W   = 2;

   localparam logic [WORD_W-1:0] SYS_CLOCK_RESET = 32'd50000000;
   localparam logic [BYTE_W-1:0] PRESCALE_MIN    = 8'd2;
   localparam logic [BYTE_W-1:0] PRESCALE_MAX    = 8'd254;
   localparam logic [BYTE_W-1:0] PRESCALE_STEP   = 8'd2;
   localparam logic [BYTE_W-1:0] POST_MAX        = 8'd255;
   localparam logic [Q_W-1:0]    Q_MAX           = 9'd256;
   // bound for prescale 2 is 257 * 2, and it grows by 257 * 2 per step
   localparam logic [DIV_W-1:0]  LIMIT_INIT      = 16'd514;
   localparam logic [DIV_W-1:0]  LIMIT_STEP      = 16'd514;

   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
   localparam logic [STATUS_W-1:0] ST_SAT  = 2'd2;

   typedef enum logic [1:0] {
      SEL_TOTAL = 2'd0,
      SEL_Q     = 2'd1,
      SEL_HZ    = 2'd2
   } div_sel_type;

   typedef struct packed {
      logic        load;
      logic        zero;
      logic        div_start;
      div_sel_type div_sel;
      logic        search_init;
      logic        search_step;
      logic        sat;
      logic        mul;
   } dp_cmd_type;

   typedef struct packed {
      logic req_zero;
      logic div_done;
      logic search_hit;
      logic search_end;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: rtl/core/scd_div.sv
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module scd_div
   import scd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [WORD_W-1:0] dividend,
   input  wire logic [WORD_W-1:0] divisor,
   output      logic              done,
   output      logic [WORD_W-1:0] quotient
);

   localparam int unsigned CNT_W = $clog2(WORD_W);

   logic              busy_ff,  busy_in;
   logic              done_ff,  done_in;
   logic [CNT_W-1:0]  cnt_ff,   cnt_in;
   logic [WORD_W-1:0] rem_ff,   rem_in;
   logic [WORD_W-1:0] quo_ff,   quo_in;
   logic [WORD_W-1:0] dvs_ff,   dvs_in;
   logic [WORD_W:0]   trial;
   logic [WORD_W:0]   diff;

   assign trial = {rem_ff, quo_ff[WORD_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // a borrow in the top bit means the trial remainder stays
         if (!diff[WORD_W]) begin
            rem_in = diff[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(WORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

FILE: rtl/core/scd_dp.sv
// datapath: clock register, clamp, prescale search, shared divider and result registers
`default_nettype none

module scd_dp
   import scd_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write_enable,
   input  wire logic [WORD_W-1:0]   csr_write_data,
   input  wire logic [WORD_W-1:0]   req_requested_hz,
   input  wire dp_cmd_type          cmd,
   output      dp_status_type       status,
   output      logic [BYTE_W-1:0]   rsp_prescale,
   output      logic [BYTE_W-1:0]   rsp_post_divider,
   output      logic [WORD_W-1:0]   rsp_actual_hz,
   output      logic [STATUS_W-1:0] rsp_status
);

   logic [WORD_W-1:0]   sys_ff;
   logic [WORD_W-1:0]   req_ff,   req_in;
   logic [WORD_W-1:0]   total_ff, total_in;
   logic [BYTE_W-1:0]   p_ff,     p_in;
   logic [DIV_W-1:0]    lim_ff,   lim_in;
   logic [Q_W-1:0]      q_ff,     q_in;
   logic [DIV_W-1:0]    div_ff,   div_in;
   logic [BYTE_W-1:0]   post_ff,  post_in;
   logic [WORD_W-1:0]   hz_ff,    hz_in;
   logic [STATUS_W-1:0] st_ff,    st_in;

   logic [WORD_W-1:0]   half;
   logic [WORD_W-1:0]   div_a;
   logic [WORD_W-1:0]   div_b;
   logic                div_done;
   logic [WORD_W-1:0]   div_q;
   logic [BYTE_W+Q_W-1:0] product;

   assign half    = sys_ff >> 1;
   assign product = p_ff * q_ff;

   always_comb begin
      div_a = sys_ff;
      div_b = req_ff;
      unique case (cmd.div_sel)
         SEL_TOTAL: begin
            div_a = sys_ff;
            div_b = req_ff;
         end
         SEL_Q: begin
            div_a = total_ff;
            div_b = {{(WORD_W-BYTE_W){1'b0}}, p_ff};
         end
         SEL_HZ: begin
            div_a = sys_ff;
            div_b = {{(WORD_W-DIV_W){1'b0}}, div_ff};
         end
         default: begin
            div_a = sys_ff;
            div_b = req_ff;
         end
      endcase
   end

   scd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      req_in   = req_ff;
      total_in = total_ff;
      p_in     = p_ff;
      lim_in   = lim_ff;
      q_in     = q_ff;
      div_in   = div_ff;
      post_in  = post_ff;
      hz_in    = hz_ff;
      st_in    = st_ff;
      if (cmd.load) begin
         req_in = (req_requested_hz > half) ? half : req_requested_hz;
         st_in  = ST_OK;
      end
      if (cmd.zero) begin
         p_in    = PRESCALE_MIN;
         post_in = '0;
         hz_in   = '0;
         st_in   = ST_ZERO;
      end
      if (div_done) begin
         unique case (cmd.div_sel)
            SEL_TOTAL: total_in = div_q;
            SEL_Q:     q_in     = div_q[Q_W-1:0];
            SEL_HZ:    hz_in    = div_q;
            default:   total_in = total_ff;
         endcase
      end
      if (cmd.search_init) begin
         p_in   = PRESCALE_MIN;
         lim_in = LIMIT_INIT;
      end
      if (cmd.search_step) begin
         p_in   = p_ff + PRESCALE_STEP;
         lim_in = lim_ff + LIMIT_STEP;
      end
      if (cmd.sat) begin
         p_in  = PRESCALE_MAX;
         q_in  = Q_MAX;
         st_in = ST_SAT;
      end
      if (cmd.mul) begin
         div_in  = product[DIV_W-1:0];
         post_in = BYTE_W'(q_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sys_ff <= SYS_CLOCK_RESET;
      end else if (csr_write_enable) begin
         sys_ff <= csr_write_data;
      end
      req_ff   <= req_in;
      total_ff <= total_in;
      p_ff     <= p_in;
      lim_ff   <= lim_in;
      q_ff     <= q_in;
      div_ff   <= div_in;
      post_ff  <= post_in;
      hz_ff    <= hz_in;
      st_ff    <= st_in;
   end

   // quotient total / p stays within 256 exactly when total < 257 * p
   assign status.req_zero   = (req_ff == '0);
   assign status.div_done   = div_done;
   assign status.search_hit = ({{(WORD_W-DIV_W){1'b0}}, lim_ff} > total_ff);
   assign status.search_end = (p_ff == PRESCALE_MAX);

   assign rsp_prescale     = p_ff;
   assign rsp_post_divider = post_ff;
   assign rsp_actual_hz    = hz_ff;
   assign rsp_status       = st_ff;

endmodule

`default_nettype wire

FILE: rtl/core/scd_ctrl.sv
// controller state machine that sequences the divisor search
`default_nettype none

module scd_ctrl
   import scd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_stall,
   output      logic          rsp_valid,
   input  wire logic          rsp_stall,
   input  wire dp_status_type status,
   output      dp_cmd_type    cmd
);

   typedef enum logic [8:0] {
      S_IDLE      = 9'b000000001,
      S_CHECK     = 9'b000000010,
      S_DIV_TOTAL = 9'b000000100,
      S_SEARCH    = 9'b000001000,
      S_DIV_Q     = 9'b000010000,
      S_MUL       = 9'b000100000,
      S_HZ_START  = 9'b001000000,
      S_DIV_HZ    = 9'b010000000,
      S_OUT       = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.div_sel = SEL_TOTAL;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.req_zero) begin
               cmd.zero = 1'b1;
               state_in = S_OUT;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV_TOTAL;
            end
         end
         S_DIV_TOTAL: begin
            if (status.div_done) begin
               cmd.search_init = 1'b1;
               state_in        = S_SEARCH;
            end
         end
         S_SEARCH: begin
            cmd.div_sel = SEL_Q;
            priority if (status.search_hit) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV_Q;
            end else if (status.search_end) begin
               cmd.sat  = 1'b1;
               state_in = S_MUL;
            end else begin
               cmd.search_step = 1'b1;
            end
         end
         S_DIV_Q: begin
            cmd.div_sel = SEL_Q;
            if (status.div_done) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_HZ_START;
         end
         S_HZ_START: begin
            cmd.div_sel   = SEL_HZ;
            cmd.div_start = 1'b1;
            state_in      = S_DIV_HZ;
         end
         S_DIV_HZ: begin
            cmd.div_sel = SEL_HZ;
            if (status.div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

endmodule

`default_nettype wire

FILE: rtl/core/spi_clock_divisor_search.sv
// top level of the serial clock divisor search block
`default_nettype none

// Turns a requested serial clock rate into an even prescale (2..254), a
// post-divider value and the resulting rate, from the system clock rate held
// in the csr register (reset value 50 MHz). One request is worked at a time:
// it is clamped to half the system clock, then a shared divider (32
// iterations a pass) forms the total divisor, a search tries one even
// prescale per cycle, and two more divider passes give the post-divider and
// the actual rate; a saturated search skips the post-divider pass. The
// result stays on the rsp_ ports until taken, and the next request is taken
// after that.
module spi_clock_divisor_search
   import scd_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write_enable,
   input  wire logic [WORD_W-1:0]   csr_write_data,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic [WORD_W-1:0]   req_requested_hz,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      logic [BYTE_W-1:0]   rsp_prescale,
   output      logic [BYTE_W-1:0]   rsp_post_divider,
   output      logic [WORD_W-1:0]   rsp_actual_hz,
   output      logic [STATUS_W-1:0] rsp_status
);

   dp_cmd_type    cmd;
   dp_status_type dp_status;

   scd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (dp_status),
      .cmd       (cmd)
   );

   scd_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_requested_hz (req_requested_hz),
      .cmd              (cmd),
      .status           (dp_status),
      .rsp_prescale     (rsp_prescale),
      .rsp_post_divider (rsp_post_divider),
      .rsp_actual_hz    (rsp_actual_hz),
      .rsp_status       (rsp_status)
   );

endmodule

`default_nettype wire

FILE: bench/spi_clock_divisor_search_tb.sv
// testbench for the serial clock divisor search: directed and random rates checked against a divisor predictor
`default_nettype none

module spi_clock_divisor_search_tb;
   import scd_pkg::*;

   localparam int unsigned IDLE_PCT       = 9;
   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam int unsigned SETTLE_CYCLES  = 250;

   typedef struct packed {
      logic [BYTE_W-1:0]   prescale;
      logic [BYTE_W-1:0]   post_divider;
      logic [WORD_W-1:0]   actual_hz;
      logic [STATUS_W-1:0] status;
   } divisor_result_type;

   class divisor_scoreboard_type;
      bit [WORD_W-1:0]    clock_hz;
      divisor_result_type expected_settings[$];
      int unsigned        errors;

      function new();
         clock_hz = SYS_CLOCK_RESET;
         errors   = 0;
      endfunction

      function void set_clock(bit [WORD_W-1:0] hz);
         clock_hz = hz;
      endfunction

      function divisor_result_type predict_divisor(bit [WORD_W-1:0] requested);
         bit [WORD_W-1:0] rate;
         bit [WORD_W-1:0] total;
         bit [WORD_W-1:0] quotient;
         bit [WORD_W-1:0] p;
         divisor_result_type r;
         rate = (requested > clock_hz / 2) ? clock_hz / 2 : requested;
         r.prescale     = PRESCALE_MIN;
         r.post_divider = '0;
         r.actual_hz    = '0;
         r.status       = ST_ZERO;
         if (rate == 0) return r;
         total = clock_hz / rate;
         for (p = PRESCALE_MIN; p <= PRESCALE_MAX; p += PRESCALE_STEP) begin
            quotient = total / p;
            if (quotient <= Q_MAX) begin
               r.prescale     = p[BYTE_W-1:0];
               r.post_divider = BYTE_W'(quotient - 1);
               r.actual_hz    = clock_hz / (p * quotient);
               r.status       = ST_OK;
               return r;
            end
         end
         // no even prescale brings the quotient into range
         r.prescale     = PRESCALE_MAX;
         r.post_divider = POST_MAX;
         r.actual_hz    = clock_hz / (PRESCALE_MAX * (POST_MAX + 1));
         r.status       = ST_SAT;
         return r;
      endfunction

      function void note_request(bit [WORD_W-1:0] requested);
         expected_settings.push_back(predict_divisor(requested));
      endfunction

      function void compare_field(string field, bit [WORD_W-1:0] exp_val,
                                  bit [WORD_W-1:0] act_val);
         if (exp_val !== act_val) begin
            $display("%0t: %s expected %0d actual %0d", $time, field, exp_val, act_val);
            errors++;
         end
      endfunction

      function void check_result(divisor_result_type got);
         divisor_result_type want;
         if (expected_settings.size() == 0) begin
            $display("%0t: unexpected response, expected none actual prescale %0d", $time,
                     got.prescale);
            errors++;
            return;
         end
         want = expected_settings.pop_front();
         compare_field("prescale", want.prescale, got.prescale);
         compare_field("post_divider", want.post_divider, got.post_divider);
         compare_field("actual_hz", want.actual_hz, got.actual_hz);
         compare_field("status", want.status, got.status);
      endfunction
   endclass

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                csr_write_enable = 1'b0;
   logic [WORD_W-1:0]   csr_write_data   = '0;
   logic                req_valid        = 1'b0;
   logic                req_stall;
   logic [WORD_W-1:0]   req_requested_hz = '0;
   logic                rsp_valid;
   logic                rsp_stall        = 1'b0;
   logic [BYTE_W-1:0]   rsp_prescale;
   logic [BYTE_W-1:0]   rsp_post_divider;
   logic [WORD_W-1:0]   rsp_actual_hz;
   logic [STATUS_W-1:0] rsp_status;

   divisor_scoreboard_type sb = new();
   bit                     quiet = 1'b0;
   int unsigned            stalled_cycles = 0;

   spi_clock_divisor_search dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_requested_hz (req_requested_hz),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_prescale     (rsp_prescale),
      .rsp_post_divider (rsp_post_divider),
      .rsp_actual_hz    (rsp_actual_hz),
      .rsp_status       (rsp_status)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result('{rsp_prescale, rsp_post_divider, rsp_actual_hz, rsp_status});
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stalled_cycles <= 0;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
         if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   task automatic send_request(bit [WORD_W-1:0] hz);
      if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 40);
      end
      req_valid        <= 1'b1;
      req_requested_hz <= hz;
      do @(posedge clock); while (req_stall);
      sb.note_request(hz);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.expected_settings.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_clock_rate(bit [WORD_W-1:0] hz);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= hz;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      csr_write_data   <= $urandom;
      sb.set_clock(hz);
   endtask

   function automatic bit [WORD_W-1:0] random_rate();
      bit [WORD_W-1:0] total;
      bit [WORD_W-1:0] half;
      half = sb.clock_hz / 2;
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return $urandom_range(0, 1000);
         2: begin
            case ($urandom_range(0, 4))
               0: return '0;
               1: return 32'd1;
               2: return '1;
               3: return half;
               default: return half + 1;
            endcase
         end
         default: begin
            // pick a total divisor across many magnitudes, then back out a rate
            total = ($urandom & ((32'd1 << $urandom_range(1, 24)) - 1)) | 32'd2;
            return sb.clock_hz / total + $urandom_range(0, 2) - 1;
         end
      endcase
   endfunction

   bit [WORD_W-1:0] clock_settings[] = '{32'hFFFF_FFFF, 32'd0, 32'd1, 32'd2, 32'd3,
                                         32'd100_000_000, 32'd16_000_000, 32'h8000_0000,
                                         32'd0, 32'd50_000_000};

   bit [WORD_W-1:0] directed[] = '{32'd0, 32'd1, 32'd2, 32'd765, 32'd766, 32'd767,
                                   32'd1000, 32'd97_276, 32'd97_655, 32'd97_656,
                                   32'd195_312, 32'd100_000, 32'd65_536,
                                   32'd24_999_999, 32'd25_000_000, 32'd25_000_001,
                                   32'h8000_0000, 32'hFFFF_FFFF, 32'h5555_5555,
                                   32'hAAAA_AAAA};

   initial begin
      int unsigned count;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      repeat (10) @(posedge clock);

      foreach (directed[i]) send_request(directed[i]);

      foreach (clock_settings[s]) begin
         // a fresh random word stands in for one of the zero settings
         write_clock_rate((s == 8) ? $urandom : clock_settings[s]);
         quiet = (s == 5);
         count = (clock_settings[s] < 4 && s != 8) ? 25 : 150;
         repeat (count) begin
            send_request(random_rate());
            if ($urandom_range(0, 99) < 2) wait_drained();
         end
         quiet = 1'b0;
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.expected_settings.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire
